// ===== hw/rtl/kvlt_pkg.sv =====
// Shared types, character codes and result kinds for the key/value line tokenizer.
// Depends on nothing; every other file of the block imports it.
package kvlt_pkg;

   localparam int BLANK_COUNT_BITS_DEFAULT = 16;
   localparam int BLANK_FIELD_BITS         = 16;
   localparam int QUEUE_DEPTH              = 4;
   localparam int QUEUE_PTR_BITS           = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS         = $clog2(QUEUE_DEPTH + 1);
   localparam int REQ_TDATA_BITS           = 8;
   localparam int RSP_TDATA_BITS           = 32;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;

   typedef enum logic [3:0] {
      PH_LINE   = 4'b0001,
      PH_KEY    = 4'b0010,
      PH_VSTART = 4'b0100,
      PH_VALUE  = 4'b1000
   } phase_type;

   typedef enum logic [3:0] {
      KIND_KEY_BYTE     = 4'd0,
      KIND_KEY_BLANKS   = 4'd1,
      KIND_KEY_END      = 4'd2,
      KIND_VALUE_BYTE   = 4'd3,
      KIND_VALUE_BLANKS = 4'd4,
      KIND_PAIR_END     = 4'd5,
      KIND_LINE_DROPPED = 4'd6,
      KIND_END_CLEAN    = 4'd7,
      KIND_END_UNTERM   = 4'd8
   } kind_type;

   typedef struct packed {
      kind_type                    kind;
      logic [7:0]                  data_byte;
      logic [BLANK_FIELD_BITS-1:0] blank_count;
      logic                        last;
   } result_type;

   // results caused by one input item, in order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic result_type make_result(kind_type kind, logic [7:0] data_byte,
                                              logic [BLANK_FIELD_BITS-1:0] blank_count);
      result_type r;
      r.kind        = kind;
      r.data_byte   = data_byte;
      r.blank_count = blank_count;
      r.last        = 1'b0;
      return r;
   endfunction

endpackage

// ===== hw/rtl/kvlt_decode.sv =====
// Next-state and result logic for one text byte of the tokenizer.
// Depends on kvlt_pkg.
module kvlt_decode
   import kvlt_pkg::*;
#(
   parameter int BLANK_COUNT_BITS = BLANK_COUNT_BITS_DEFAULT
) (
   input  logic [7:0]                  text_byte,
   input  logic                        end_of_input,
   input  phase_type                   phase,
   input  logic [BLANK_COUNT_BITS-1:0] pending_blanks,
   input  logic                        after_cr,
   output phase_type                   phase_in,
   output logic [BLANK_COUNT_BITS-1:0] pending_blanks_in,
   output logic                        after_cr_in,
   output push_type                    push
);

   logic                        is_end;
   logic                        is_blank;
   logic [BLANK_COUNT_BITS-1:0] blanks_inc;
   logic [31:0]                 blanks_wide;
   logic [BLANK_FIELD_BITS-1:0] blanks_field;

   assign is_end       = end_of_input || (text_byte == CHAR_NUL);
   assign is_blank     = (text_byte == CHAR_SPACE) || (text_byte == CHAR_TAB);
   // count saturates at all ones
   assign blanks_inc   = (pending_blanks == '1) ? pending_blanks
                                                : pending_blanks + 1'b1;
   assign blanks_wide  = 32'(pending_blanks);
   assign blanks_field = blanks_wide[BLANK_FIELD_BITS-1:0];

   always_comb begin
      phase_in          = phase;
      pending_blanks_in = pending_blanks;
      after_cr_in       = after_cr;
      push.count        = 2'd0;
      push.first        = make_result(KIND_KEY_BYTE, 8'h00, '0);
      push.second       = make_result(KIND_KEY_BYTE, 8'h00, '0);

      if (is_end) begin
         if (phase == PH_KEY || phase == PH_VSTART || phase == PH_VALUE) begin
            push.count  = 2'd2;
            push.first  = make_result(KIND_LINE_DROPPED, 8'h00, '0);
            push.second = make_result(KIND_END_UNTERM, 8'h00, '0);
         end else begin
            push.count = 2'd1;
            push.first = make_result(KIND_END_CLEAN, 8'h00, '0);
         end
         phase_in          = PH_LINE;
         pending_blanks_in = '0;
         after_cr_in       = 1'b0;
      end else if (after_cr && text_byte == CHAR_LF) begin
         // second half of CR LF
         after_cr_in = 1'b0;
      end else begin
         after_cr_in = 1'b0;
         if (text_byte == CHAR_LF || text_byte == CHAR_CR) begin
            after_cr_in = (text_byte == CHAR_CR);
            case (phase)
               PH_KEY: begin
                  push.count = 2'd1;
                  push.first = make_result(KIND_LINE_DROPPED, 8'h00, '0);
               end
               PH_VSTART, PH_VALUE: begin
                  push.count = 2'd1;
                  push.first = make_result(KIND_PAIR_END, 8'h00, '0);
               end
               default: begin
               end
            endcase
            phase_in          = PH_LINE;
            pending_blanks_in = '0;
         end else begin
            case (phase)
               PH_KEY: begin
                  if (is_blank) begin
                     pending_blanks_in = blanks_inc;
                  end else if (text_byte == CHAR_EQUAL) begin
                     push.count        = 2'd1;
                     push.first        = make_result(KIND_KEY_END, 8'h00, '0);
                     pending_blanks_in = '0;
                     phase_in          = PH_VSTART;
                  end else if (pending_blanks != '0) begin
                     push.count        = 2'd2;
                     push.first        = make_result(KIND_KEY_BLANKS, 8'h00, blanks_field);
                     push.second       = make_result(KIND_KEY_BYTE, text_byte, '0);
                     pending_blanks_in = '0;
                  end else begin
                     push.count = 2'd1;
                     push.first = make_result(KIND_KEY_BYTE, text_byte, '0);
                  end
               end
               PH_VSTART: begin
                  if (!is_blank) begin
                     push.count = 2'd1;
                     push.first = make_result(KIND_VALUE_BYTE, text_byte, '0);
                     phase_in   = PH_VALUE;
                  end
               end
               PH_VALUE: begin
                  if (is_blank) begin
                     pending_blanks_in = blanks_inc;
                  end else if (pending_blanks != '0) begin
                     push.count        = 2'd2;
                     push.first        = make_result(KIND_VALUE_BLANKS, 8'h00, blanks_field);
                     push.second       = make_result(KIND_VALUE_BYTE, text_byte, '0);
                     pending_blanks_in = '0;
                  end else begin
                     push.count = 2'd1;
                     push.first = make_result(KIND_VALUE_BYTE, text_byte, '0);
                  end
               end
               default: begin
                  pending_blanks_in = '0;
                  phase_in          = PH_LINE;
                  if (text_byte == CHAR_EQUAL) begin
                     push.count = 2'd1;
                     push.first = make_result(KIND_KEY_END, 8'h00, '0);
                     phase_in   = PH_VSTART;
                  end else if (!is_blank) begin
                     push.count = 2'd1;
                     push.first = make_result(KIND_KEY_BYTE, text_byte, '0);
                     phase_in   = PH_KEY;
                  end
               end
            endcase
         end
      end

      if (push.count == 2'd1) begin
         push.first.last = 1'b1;
      end
      if (push.count == 2'd2) begin
         push.second.last = 1'b1;
      end
   end

endmodule

// ===== hw/rtl/kvlt_result_queue.sv =====
// Small result queue: takes up to two results a cycle, hands out one.
// Depends on kvlt_pkg.
module kvlt_result_queue
   import kvlt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_en,
   input  push_type   push,
   output logic       room,
   output logic       head_valid,
   output result_type head,
   input  logic       pop
);

   result_type                  queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;
   logic [QUEUE_COUNT_BITS-1:0] push_n;
   logic                        do_pop;

   // room for a full two-result item regardless of the output side
   assign room       = (count_ff <= QUEUE_COUNT_BITS'(QUEUE_DEPTH - 2));
   assign head_valid = (count_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;
   assign push_n     = push_en ? QUEUE_COUNT_BITS'(push.count) : '0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(push_n);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(do_pop);
      count_in  = count_ff + push_n - QUEUE_COUNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != '0) begin
         queue_ff[wr_ptr_ff] <= push.first;
      end
      if (push_n == QUEUE_COUNT_BITS'(2)) begin
         queue_ff[wr_ptr_ff + QUEUE_PTR_BITS'(1)] <= push.second;
      end
   end

endmodule

// ===== hw/rtl/key_value_line_tokenizer_top.sv =====
// Key/value line tokenizer: one text byte per req item, results as a stream of rsp items.
// A byte is taken every cycle while the four-entry result queue has room for two
// results, and the output side hands out one result per cycle while rsp_tready is high;
// a byte may yield two results (a blank run followed by a character, or end of input
// inside a line). Results are written into the result queue registers before they
// appear on rsp.
// Depends on kvlt_pkg, kvlt_decode and kvlt_result_queue.
module key_value_line_tokenizer_top
   import kvlt_pkg::*;
#(
   parameter int BLANK_COUNT_BITS = BLANK_COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,   // [7:0] text_byte
   input  logic                      req_tuser,   // [0] end_of_input
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,   // [3:0] kind, [11:4] data_byte,
                                                  // [27:12] blank_count, [31:28] zero
   output logic                      rsp_tlast    // last result of the input item
);

   phase_type                   phase_ff, phase_in;
   logic [BLANK_COUNT_BITS-1:0] pending_blanks_ff, pending_blanks_in;
   logic                        after_cr_ff, after_cr_in;
   push_type                    push;
   result_type                  head;
   logic                        accept;

   assign accept = req_tvalid && req_tready;

   kvlt_decode #(
      .BLANK_COUNT_BITS(BLANK_COUNT_BITS)
   ) u_decode (
      .text_byte        (req_tdata[7:0]),
      .end_of_input     (req_tuser),
      .phase            (phase_ff),
      .pending_blanks   (pending_blanks_ff),
      .after_cr         (after_cr_ff),
      .phase_in         (phase_in),
      .pending_blanks_in(pending_blanks_in),
      .after_cr_in      (after_cr_in),
      .push             (push)
   );

   kvlt_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (accept),
      .push      (push),
      .room      (req_tready),
      .head_valid(rsp_tvalid),
      .head      (head),
      .pop       (rsp_tready)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_LINE;
         pending_blanks_ff <= '0;
         after_cr_ff       <= 1'b0;
      end else if (accept) begin
         phase_ff          <= phase_in;
         pending_blanks_ff <= pending_blanks_in;
         after_cr_ff       <= after_cr_in;
      end
   end

   assign rsp_tdata = {4'b0000, head.blank_count, head.data_byte, head.kind};
   assign rsp_tlast = head.last;

endmodule

// ===== tb/tb_key_value_line_tokenizer_top.sv =====
// Self-checking testbench for key_value_line_tokenizer_top: directed lines, one long
// blank run and random text under four idle patterns, checked against a tokenizer model here.
// Depends on kvlt_pkg and the block's RTL.
module tb_key_value_line_tokenizer_top;
   timeunit 1ns;
   timeprecision 1ps;
   import kvlt_pkg::*;

   localparam int BLANK_BITS  = BLANK_COUNT_BITS_DEFAULT;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int MAX_REPORTS = 10;
   localparam int LONG_RUN    = 24;
   localparam int PHASE_ITEMS = 200;
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      logic       eoi;
      logic [7:0] text;
   } text_item_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;
   logic                      req_tuser  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      rsp_tlast;

   text_item_type text_queue[$];
   result_type    expected_tokens[$];

   // tokenizer state as seen by the checker
   phase_type             line_phase  = PH_LINE;
   logic [BLANK_BITS-1:0] held_blanks = '0;
   logic                  saw_cr      = 1'b0;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int queued             = 0;
   int items_accepted     = 0;
   int results_seen       = 0;
   int mismatches         = 0;
   int cycles             = 0;

   key_value_line_tokenizer_top #(
      .BLANK_COUNT_BITS(BLANK_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic result_type token(input kind_type k, input logic [7:0] d,
                                        input logic [BLANK_FIELD_BITS-1:0] c);
      result_type t;
      t.kind        = k;
      t.data_byte   = d;
      t.blank_count = c;
      t.last        = 1'b0;
      return t;
   endfunction

   // expected results for one accepted text byte; updates the checker's state
   task automatic tokenize_byte(input logic [7:0] b, input logic eoi);
      result_type outs[$];
      logic       blank;
      blank = (b == CHAR_SPACE) || (b == CHAR_TAB);
      if (eoi || b == CHAR_NUL) begin
         if (line_phase == PH_KEY || line_phase == PH_VSTART || line_phase == PH_VALUE) begin
            outs.push_back(token(KIND_LINE_DROPPED, 8'h00, '0));
            outs.push_back(token(KIND_END_UNTERM, 8'h00, '0));
         end else begin
            outs.push_back(token(KIND_END_CLEAN, 8'h00, '0));
         end
         line_phase  = PH_LINE;
         held_blanks = '0;
         saw_cr      = 1'b0;
      end else if (saw_cr && b == CHAR_LF) begin
         saw_cr = 1'b0;    // second half of CR LF
      end else begin
         saw_cr = 1'b0;
         if (b == CHAR_LF || b == CHAR_CR) begin
            saw_cr = (b == CHAR_CR);
            if (line_phase == PH_KEY)
               outs.push_back(token(KIND_LINE_DROPPED, 8'h00, '0));
            else if (line_phase == PH_VSTART || line_phase == PH_VALUE)
               outs.push_back(token(KIND_PAIR_END, 8'h00, '0));
            line_phase  = PH_LINE;
            held_blanks = '0;
         end else if (line_phase == PH_KEY) begin
            if (blank) begin
               if (held_blanks != '1) held_blanks++;
            end else if (b == CHAR_EQUAL) begin
               outs.push_back(token(KIND_KEY_END, 8'h00, '0));
               held_blanks = '0;
               line_phase  = PH_VSTART;
            end else begin
               if (held_blanks != '0)
                  outs.push_back(token(KIND_KEY_BLANKS, 8'h00,
                                       BLANK_FIELD_BITS'(held_blanks)));
               held_blanks = '0;
               outs.push_back(token(KIND_KEY_BYTE, b, '0));
            end
         end else if (line_phase == PH_VSTART) begin
            if (!blank) begin
               outs.push_back(token(KIND_VALUE_BYTE, b, '0));
               line_phase = PH_VALUE;
            end
         end else if (line_phase == PH_VALUE) begin
            if (blank) begin
               if (held_blanks != '1) held_blanks++;
            end else begin
               if (held_blanks != '0)
                  outs.push_back(token(KIND_VALUE_BLANKS, 8'h00,
                                       BLANK_FIELD_BITS'(held_blanks)));
               held_blanks = '0;
               outs.push_back(token(KIND_VALUE_BYTE, b, '0));
            end
         end else begin
            line_phase  = PH_LINE;
            held_blanks = '0;
            if (b == CHAR_EQUAL) begin
               outs.push_back(token(KIND_KEY_END, 8'h00, '0));
               line_phase = PH_VSTART;
            end else if (!blank) begin
               outs.push_back(token(KIND_KEY_BYTE, b, '0));
               line_phase = PH_KEY;
            end
         end
      end
      if (outs.size() != 0) outs[outs.size()-1].last = 1'b1;
      foreach (outs[i]) expected_tokens.push_back(outs[i]);
   endtask

   // driver: one byte per handshake, random gaps
   always @(posedge clock) begin : drive
      text_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            tokenize_byte(req_tdata, req_tuser);
            items_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (text_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               item = text_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= item.text;
               req_tuser  <= item.eoi;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic note_mismatch(input result_type want, input bit have_want);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         if (have_want)
            $display("mismatch at result %0d: expected kind %0d byte %02h blanks %0d last %0b",
                     results_seen, want.kind, want.data_byte, want.blank_count, want.last);
         else
            $display("mismatch at result %0d: no result expected", results_seen);
         $display("   got kind %0d byte %02h blanks %0d last %0b",
                  rsp_tdata[3:0], rsp_tdata[11:4], rsp_tdata[27:12], rsp_tlast);
      end
   endtask

   // monitor: compares each result item with the oldest expectation
   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_tokens.size() == 0) begin
               want = token(KIND_KEY_BYTE, 8'h00, '0);
               note_mismatch(want, 1'b0);
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_tdata[3:0] !== want.kind || rsp_tdata[11:4] !== want.data_byte ||
                   rsp_tdata[27:12] !== want.blank_count || rsp_tlast !== want.last)
                  note_mismatch(want, 1'b1);
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycles, expected_tokens.size());
         $display("Verification failed");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      text_queue.push_back('{eoi: 1'b0, text: b});
      queued++;
   endtask

   task automatic push_end(input logic [7:0] b);
      text_queue.push_back('{eoi: 1'b1, text: b});
      queued++;
   endtask

   task automatic push_blanks(input int n);
      repeat (n) push_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
   endtask

   // any byte that is not a blank, line end, '=' or NUL; mostly printable
   function automatic logic [7:0] pick_char();
      logic [7:0] c;
      do begin
         if ($urandom_range(0, 4) == 0) c = 8'($urandom_range(1, 255));
         else c = 8'($urandom_range(33, 126));
      end while (c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR || c == CHAR_SPACE ||
                 c == CHAR_EQUAL);
      return c;
   endfunction

   task automatic push_word(input int len, input bit allow_equal);
      for (int i = 0; i < len; i++) begin
         if (i != 0 && $urandom_range(0, 3) == 0) push_blanks($urandom_range(1, 3));
         if (allow_equal && $urandom_range(0, 9) == 0) push_byte(CHAR_EQUAL);
         else push_byte(pick_char());
      end
   endtask

   task automatic push_line_end();
      case ($urandom_range(0, 2))
         0: push_byte(CHAR_LF);
         1: push_byte(CHAR_CR);
         default: begin
            push_byte(CHAR_CR);
            push_byte(CHAR_LF);
         end
      endcase
   endtask

   task automatic push_random_text(input int count);
      int stop;
      int pick;
      stop = queued + count;
      while (queued < stop) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            // well-formed pair, key or value sometimes empty
            push_blanks($urandom_range(0, 2));
            if ($urandom_range(0, 6) != 0) push_word($urandom_range(1, 8), 1'b0);
            push_blanks($urandom_range(0, 2));
            push_byte(CHAR_EQUAL);
            push_blanks($urandom_range(0, 2));
            if ($urandom_range(0, 6) != 0) push_word($urandom_range(1, 8), 1'b1);
            push_blanks($urandom_range(0, 2));
            if ($urandom_range(0, 19) == 0) push_end(8'($urandom_range(0, 255)));
            else push_line_end();
         end else if (pick < 80) begin
            // no '=' on the line
            push_blanks($urandom_range(0, 2));
            push_word($urandom_range(1, 6), 1'b0);
            push_blanks($urandom_range(0, 2));
            if ($urandom_range(0, 9) == 0) push_byte(CHAR_NUL);
            else push_line_end();
         end else if (pick < 87) begin
            push_blanks($urandom_range(0, 4));
            push_line_end();
         end else if (pick < 94) begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(1, 255)));
         end else if ($urandom_range(0, 1) == 0) begin
            push_byte(CHAR_NUL);
         end else begin
            push_end(8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic drain();
      do @(negedge clock);
      while (text_queue.size() != 0 || req_tvalid || expected_tokens.size() != 0);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // blank-only line
      push_byte(CHAR_SPACE);
      push_byte(CHAR_TAB);
      push_byte(CHAR_LF);
      // empty key, CR LF as one line end
      push_byte(CHAR_EQUAL);
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);
      // interior blanks, blanks around '=', second '=' in value, CR alone
      push_byte("k");
      push_byte(CHAR_SPACE);
      push_byte("y");
      push_byte(CHAR_SPACE);
      push_byte(CHAR_EQUAL);
      push_byte(CHAR_SPACE);
      push_byte("v");
      push_byte(CHAR_EQUAL);
      push_byte(CHAR_TAB);
      push_byte("w");
      push_byte(CHAR_CR);
      // byte after a lone CR, then a line without '='
      push_byte("a");
      push_byte(CHAR_LF);
      // end of input inside a key, then on an empty line
      push_byte(8'hFF);
      push_end(8'h41);
      push_byte(CHAR_NUL);
      // NUL inside a value
      push_byte(CHAR_EQUAL);
      push_byte("q");
      push_byte(CHAR_NUL);

      // long interior blank run in a key
      push_byte("a");
      push_blanks(LONG_RUN);
      push_byte("b");
      push_byte(CHAR_LF);

      push_random_text(PHASE_ITEMS);
      drain();

      sender_idle_pct = 66;
      push_random_text(PHASE_ITEMS);
      drain();

      sender_idle_pct    = 0;
      receiver_stall_pct = 66;
      push_random_text(PHASE_ITEMS);
      drain();

      sender_idle_pct    = 24;
      receiver_stall_pct = 24;
      push_random_text(PHASE_ITEMS);
      drain();

      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Sent %0d text items (directed lines, a %0d-blank run, random text under",
               items_accepted, LONG_RUN);
      $display("four idle patterns); %0d results checked, %0d mismatches.",
               results_seen, mismatches);
      if (mismatches == 0 && expected_tokens.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
